// ----- design/jhe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jhe_pkg
// Shared types and constants of the JPEG baseline Huffman block encoder.
// ----------------------------------------------------------------------------
package jhe_pkg;

  // Default sizes
  localparam int NUM_COMPONENTS_DEF = 4;
  localparam int NUM_TABLE_SETS_DEF = 2;
  localparam int MAX_CODE_BITS_DEF  = 16;

  // Field widths
  localparam int LEN_W     = 5;   // code length field of a table entry
  localparam int SUF_W     = 15;  // suffix bits
  localparam int NSUF_W    = 4;   // suffix length
  localparam int ZRL_CNT_W = 2;   // ZRL escapes before the final symbol
  localparam int PACK_W    = 31;
  localparam int CNT_W     = 5;

  // Table geometry: AC tables first, DC tables after them
  localparam int AC_ENTRIES = 256;
  localparam int DC_ENTRIES = 16;

  // Special symbols
  localparam logic [7:0] SYM_ZRL  = 8'hf0;
  localparam logic [7:0] SYM_EOB  = 8'h00;
  localparam logic [5:0] LAST_POS = 6'd63;

  typedef enum logic [2:0] {
    CMD_LOAD  = 3'd0,
    CMD_DC    = 3'd1,
    CMD_AC    = 3'd2,
    CMD_END   = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_t;

  // Per-item data carried from the symbol stage to the packing stage
  typedef struct packed {
    logic [ZRL_CNT_W-1:0] zrl_cnt;
    logic [NSUF_W-1:0]    nsuf;
    logic [SUF_W-1:0]     suffix;
  } item_t;

endpackage
`default_nettype wire

// ----- design/jpeg_huffman_block_encoder_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jpeg_huffman_block_encoder_core
// JPEG baseline Huffman entropy encoder: loads code tables, codes DC
// differences, AC run/size symbols with ZRL escapes, and end-of-block.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  --------  ---------  ---------------------------  ------------------------------
//  item      in         item_valid / item_stall      cmd .. table_len
//  result    out        result_valid / result_stall  packed_bits, bit_count,
//                                                    last_of_run
//  config    in         APB (psel, penable, pwrite)  comp_table_map at 0x0
//
//  Throughput: one item per cycle while no result stall or ZRL escape holds
//  the packing stage. An AC item with run r emits r/16 ZRL escapes, then its
//  symbol, one result per cycle through the single result register while
//  result_stall is low; other items emit one result or none.
//  A result passes the input register, table memory read and result register.
//  Reset clears the pipeline valids, the DC predictors and the table map;
//  code tables are unknown until loaded.
//  A stalled result holds its register; the packing stage and input register
//  keep accepting until both are full.
//
module jpeg_huffman_block_encoder_core #(
  parameter int NUM_COMPONENTS = jhe_pkg::NUM_COMPONENTS_DEF,
  parameter int NUM_TABLE_SETS = jhe_pkg::NUM_TABLE_SETS_DEF,
  parameter int MAX_CODE_BITS  = jhe_pkg::MAX_CODE_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // item channel
  input  wire logic         item_valid,
  output logic              item_stall,
  input  wire logic [2:0]   cmd,
  input  wire logic [1:0]   component,
  input  wire logic [10:0]  dc_value,
  input  wire logic [5:0]   run,
  input  wire logic [3:0]   size_cat,
  input  wire logic [14:0]  suffix_bits,
  input  wire logic [5:0]   last_position,
  input  wire logic         table_is_ac,
  input  wire logic         table_num,
  input  wire logic [7:0]   table_symbol,
  input  wire logic [15:0]  table_code,
  input  wire logic [4:0]   table_len,
  // result channel
  output logic              result_valid,
  input  wire logic         result_stall,
  output logic [30:0]       packed_bits,
  output logic [4:0]        bit_count,
  output logic              last_of_run,
  // configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int Depth  = NUM_TABLE_SETS * (jhe_pkg::AC_ENTRIES + jhe_pkg::DC_ENTRIES);
  localparam int AddrW  = $clog2(Depth);
  localparam int EntryW = MAX_CODE_BITS + jhe_pkg::LEN_W;

  localparam logic REG_COMP_TABLE_MAP = 1'b0;

  // Configuration register: register index sits in paddr[2]
  logic [3:0] comp_table_map;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_table_map <= '0;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == REG_COMP_TABLE_MAP)) begin
      comp_table_map <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == REG_COMP_TABLE_MAP) ? {28'd0, comp_table_map} : 32'd0;

  // Table memory and stage links
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic              ram_re;
  logic [AddrW-1:0]  ram_raddr_main;
  logic [AddrW-1:0]  ram_raddr_zrl;
  logic [EntryW-1:0] entry_main;
  logic [EntryW-1:0] entry_zrl;
  logic              fwd_valid;
  jhe_pkg::item_t    fwd_item;
  logic              take;

  jhe_symbol #(
    .NUM_COMPONENTS (NUM_COMPONENTS),
    .NUM_TABLE_SETS (NUM_TABLE_SETS),
    .MAX_CODE_BITS  (MAX_CODE_BITS)
  ) u_symbol (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .cmd            (cmd),
    .component      (component),
    .dc_value       (dc_value),
    .run            (run),
    .size_cat       (size_cat),
    .suffix_bits    (suffix_bits),
    .last_position  (last_position),
    .table_is_ac    (table_is_ac),
    .table_num      (table_num),
    .table_symbol   (table_symbol),
    .table_code     (table_code),
    .table_len      (table_len),
    .comp_table_map (comp_table_map),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr_main (ram_raddr_main),
    .ram_raddr_zrl  (ram_raddr_zrl),
    .fwd_valid      (fwd_valid),
    .fwd_item       (fwd_item),
    .take           (take)
  );

  // AC tables of all sets, then DC tables; port a reads the coded symbol,
  // port b the ZRL entry of the same set
  jhe_ram #(
    .WIDTH (EntryW),
    .DEPTH (Depth)
  ) u_table_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (ram_raddr_main),
    .raddr_b (ram_raddr_zrl),
    .rdata_a (entry_main),
    .rdata_b (entry_zrl)
  );

  jhe_pack #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_pack (
    .clk          (clk),
    .rst          (rst),
    .fwd_valid    (fwd_valid),
    .fwd_item     (fwd_item),
    .take         (take),
    .entry_main   (entry_main),
    .entry_zrl    (entry_zrl),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .packed_bits  (packed_bits),
    .bit_count    (bit_count),
    .last_of_run  (last_of_run)
  );

`ifndef SYNTHESIS
  // A table read only happens when the packing stage takes the item
  a_read_on_take: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> take)
    else $error("table read while packing stage is busy");

  // The input side only waits behind an item that has results to deliver
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (fwd_valid && !take))
    else $error("item stall without a pending result item");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result_valid && !item_stall))
    else $error("pipeline not empty after reset");
`endif

endmodule
`default_nettype wire

// ----- design/jhe_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jhe_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module jhe_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 544
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

// ----- design/jhe_symbol.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jhe_symbol
// Input register, DC predictors, category and table address generation.
// ----------------------------------------------------------------------------
module jhe_symbol #(
  parameter int NUM_COMPONENTS = jhe_pkg::NUM_COMPONENTS_DEF,
  parameter int NUM_TABLE_SETS = jhe_pkg::NUM_TABLE_SETS_DEF,
  parameter int MAX_CODE_BITS  = jhe_pkg::MAX_CODE_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         item_valid,
  output logic              item_stall,
  input  wire logic [2:0]   cmd,
  input  wire logic [1:0]   component,
  input  wire logic [10:0]  dc_value,
  input  wire logic [5:0]   run,
  input  wire logic [3:0]   size_cat,
  input  wire logic [14:0]  suffix_bits,
  input  wire logic [5:0]   last_position,
  input  wire logic         table_is_ac,
  input  wire logic         table_num,
  input  wire logic [7:0]   table_symbol,
  input  wire logic [15:0]  table_code,
  input  wire logic [4:0]   table_len,
  input  wire logic [3:0]   comp_table_map,
  // table memory
  output logic                                                 ram_we,
  output logic [$clog2(NUM_TABLE_SETS*(jhe_pkg::AC_ENTRIES
                 + jhe_pkg::DC_ENTRIES))-1:0]                  ram_waddr,
  output logic [MAX_CODE_BITS+jhe_pkg::LEN_W-1:0]              ram_wdata,
  output logic                                                 ram_re,
  output logic [$clog2(NUM_TABLE_SETS*(jhe_pkg::AC_ENTRIES
                 + jhe_pkg::DC_ENTRIES))-1:0]                  ram_raddr_main,
  output logic [$clog2(NUM_TABLE_SETS*(jhe_pkg::AC_ENTRIES
                 + jhe_pkg::DC_ENTRIES))-1:0]                  ram_raddr_zrl,
  // to packing stage
  output logic              fwd_valid,
  output jhe_pkg::item_t    fwd_item,
  input  wire logic         take
);

  localparam int Depth  = NUM_TABLE_SETS * (jhe_pkg::AC_ENTRIES + jhe_pkg::DC_ENTRIES);
  localparam int AddrW  = $clog2(Depth);
  localparam int DcBase = NUM_TABLE_SETS * jhe_pkg::AC_ENTRIES;

  function automatic logic [jhe_pkg::SUF_W-1:0] low_mask(input logic [3:0] n);
    logic [15:0] m;
    m = (16'd1 << n) - 16'd1;
    return m[jhe_pkg::SUF_W-1:0];
  endfunction

  // Input register
  logic        s1_valid;
  logic [2:0]  s1_cmd;
  logic [1:0]  s1_component;
  logic [10:0] s1_dc_value;
  logic [5:0]  s1_run;
  logic [3:0]  s1_size_cat;
  logic [14:0] s1_suffix_bits;
  logic [5:0]  s1_last_position;
  logic        s1_table_is_ac;
  logic        s1_table_num;
  logic [7:0]  s1_table_symbol;
  logic [15:0] s1_table_code;
  logic [4:0]  s1_table_len;

  logic [10:0] pred [NUM_COMPONENTS];

  logic        comp_ok;
  logic        tnum_ok;
  logic        set_sel;
  logic        has_result;
  logic        s1_adv;
  logic [10:0] pred_cur;
  logic [11:0] diff;
  logic [11:0] mag;
  logic [11:0] dc_suf_raw;
  logic [3:0]  dc_cat;
  logic [7:0]  ac_sym;
  logic [4:0]  len_sat;
  logic [16:0] code_mask;
  logic [15:0] code_m;

  always_comb begin
    pred_cur = '0;
    for (int c = 0; c < NUM_COMPONENTS; c++) begin
      if (int'(s1_component) == c) begin
        pred_cur = pred[c];
      end
    end
  end

  always_comb begin
    comp_ok = int'(s1_component) < NUM_COMPONENTS;
    tnum_ok = int'(s1_table_num) < NUM_TABLE_SETS;
    set_sel = (NUM_TABLE_SETS > 1) ? comp_table_map[s1_component] : 1'b0;

    // DC difference and magnitude category
    diff       = {s1_dc_value[10], s1_dc_value} - {pred_cur[10], pred_cur};
    mag        = diff[11] ? (12'd0 - diff) : diff;
    dc_suf_raw = diff[11] ? (diff - 12'd1) : diff;
    dc_cat     = '0;
    for (int i = 0; i < 12; i++) begin
      if (mag[i]) begin
        dc_cat = 4'(i + 1);
      end
    end

    ac_sym = {s1_run[3:0], s1_size_cat};

    // Load entry: saturate length, mask code to it
    len_sat   = (int'(s1_table_len) > MAX_CODE_BITS) ? 5'(MAX_CODE_BITS) : s1_table_len;
    code_mask = (17'd1 << len_sat) - 17'd1;
    code_m    = s1_table_code & code_mask[15:0];
  end

  always_comb begin
    has_result     = 1'b0;
    ram_raddr_main = AddrW'({set_sel, jhe_pkg::SYM_EOB});
    fwd_item       = '0;
    unique case (s1_cmd)
      jhe_pkg::CMD_DC: begin
        has_result      = comp_ok;
        ram_raddr_main  = AddrW'(DcBase) + AddrW'({set_sel, dc_cat});
        fwd_item.nsuf   = dc_cat;
        fwd_item.suffix = jhe_pkg::SUF_W'(dc_suf_raw) & low_mask(dc_cat);
      end
      jhe_pkg::CMD_AC: begin
        has_result       = comp_ok;
        ram_raddr_main   = AddrW'({set_sel, ac_sym});
        fwd_item.zrl_cnt = s1_run[5:4];
        fwd_item.nsuf    = s1_size_cat;
        fwd_item.suffix  = s1_suffix_bits & low_mask(s1_size_cat);
      end
      jhe_pkg::CMD_END: begin
        has_result = comp_ok && (s1_last_position != jhe_pkg::LAST_POS);
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  assign ram_raddr_zrl = AddrW'({set_sel, jhe_pkg::SYM_ZRL});

  assign fwd_valid  = s1_valid && has_result;
  assign s1_adv     = s1_valid && (!has_result || take);
  assign ram_re     = fwd_valid && take;
  assign item_stall = s1_valid && !s1_adv;

  // Table load; loads never wait, so the write lands as the item leaves
  assign ram_we    = s1_valid && (s1_cmd == jhe_pkg::CMD_LOAD) && tnum_ok
                     && (s1_table_is_ac || (s1_table_symbol[7:4] == 4'd0));
  assign ram_waddr = s1_table_is_ac
                     ? AddrW'({s1_table_num, s1_table_symbol})
                     : AddrW'(DcBase) + AddrW'({s1_table_num, s1_table_symbol[3:0]});
  assign ram_wdata = {code_m[MAX_CODE_BITS-1:0], len_sat};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      for (int c = 0; c < NUM_COMPONENTS; c++) begin
        pred[c] <= '0;
      end
    end else begin
      if (!item_stall) begin
        s1_valid <= item_valid;
      end
      if (s1_valid && (s1_cmd == jhe_pkg::CMD_CLEAR)) begin
        for (int c = 0; c < NUM_COMPONENTS; c++) begin
          pred[c] <= '0;
        end
      end else if (s1_adv && (s1_cmd == jhe_pkg::CMD_DC) && comp_ok) begin
        for (int c = 0; c < NUM_COMPONENTS; c++) begin
          if (int'(s1_component) == c) begin
            pred[c] <= s1_dc_value;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_cmd           <= cmd;
      s1_component     <= component;
      s1_dc_value      <= dc_value;
      s1_run           <= run;
      s1_size_cat      <= size_cat;
      s1_suffix_bits   <= suffix_bits;
      s1_last_position <= last_position;
      s1_table_is_ac   <= table_is_ac;
      s1_table_num     <= table_num;
      s1_table_symbol  <= table_symbol;
      s1_table_code    <= table_code;
      s1_table_len     <= table_len;
    end
  end

endmodule
`default_nettype wire

// ----- design/jhe_pack.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jhe_pack
// ZRL expansion, code and suffix packing, and the result register.
// ----------------------------------------------------------------------------
module jhe_pack #(
  parameter int MAX_CODE_BITS = jhe_pkg::MAX_CODE_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    fwd_valid,
  input  wire jhe_pkg::item_t                          fwd_item,
  output logic                                         take,
  input  wire logic [MAX_CODE_BITS+jhe_pkg::LEN_W-1:0] entry_main,
  input  wire logic [MAX_CODE_BITS+jhe_pkg::LEN_W-1:0] entry_zrl,
  output logic                                         result_valid,
  input  wire logic                                    result_stall,
  output logic [jhe_pkg::PACK_W-1:0]                   packed_bits,
  output logic [jhe_pkg::CNT_W-1:0]                    bit_count,
  output logic                                         last_of_run
);

  localparam int LenW = jhe_pkg::LEN_W;

  logic                          s2_valid;
  logic [jhe_pkg::ZRL_CNT_W-1:0] zrl_left;
  logic [jhe_pkg::NSUF_W-1:0]    s2_nsuf;
  logic [jhe_pkg::SUF_W-1:0]     s2_suffix;

  logic                          out_ready;
  logic                          emit;
  logic                          emit_last;
  logic [MAX_CODE_BITS-1:0]      main_code;
  logic [LenW-1:0]               main_len;
  logic [MAX_CODE_BITS-1:0]      zrl_code;
  logic [LenW-1:0]               zrl_len;
  logic [jhe_pkg::PACK_W-1:0]    packed_next;
  logic [jhe_pkg::CNT_W-1:0]     count_next;

  assign out_ready = !result_valid || !result_stall;
  assign emit      = s2_valid && out_ready;
  assign emit_last = emit && (zrl_left == '0);
  assign take      = !s2_valid || emit_last;

  assign main_code = entry_main[MAX_CODE_BITS+LenW-1:LenW];
  assign main_len  = entry_main[LenW-1:0];
  assign zrl_code  = entry_zrl[MAX_CODE_BITS+LenW-1:LenW];
  assign zrl_len   = entry_zrl[LenW-1:0];

  // ZRL escapes go out first, then the coded symbol with its suffix
  always_comb begin
    if (zrl_left != '0) begin
      packed_next = jhe_pkg::PACK_W'(zrl_code);
      count_next  = zrl_len;
    end else begin
      packed_next = (jhe_pkg::PACK_W'(main_code) << s2_nsuf)
                    | jhe_pkg::PACK_W'(s2_suffix);
      count_next  = main_len + jhe_pkg::CNT_W'(s2_nsuf);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (take) begin
        s2_valid <= fwd_valid;
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && fwd_valid) begin
      zrl_left  <= fwd_item.zrl_cnt;
      s2_nsuf   <= fwd_item.nsuf;
      s2_suffix <= fwd_item.suffix;
    end else if (emit && !emit_last) begin
      zrl_left <= zrl_left - jhe_pkg::ZRL_CNT_W'(1);
    end
    if (emit) begin
      packed_bits <= packed_next;
      bit_count   <= count_next;
      last_of_run <= emit_last;
    end
  end

endmodule
`default_nettype wire
